// ===== rtl/core/ncm_transfer_block_builder_assert.svh =====
// Assertion macros for the checker file of the NCM transfer block builder.
`ifndef NCM_TRANSFER_BLOCK_BUILDER_ASSERT_SVH
`define NCM_TRANSFER_BLOCK_BUILDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NCMTB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NCMTB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ncmtb_pkg.sv =====
// Shared constants and codes of the NCM transfer block builder.
package ncmtb_pkg;

	localparam int NCMTB_MAX_ENTRIES = 32;

	localparam int OFF_W = 32;
	localparam int LEN_W = 16;
	localparam int SEQ_W = 16;

	// request codes (s_tuser)
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	// result kinds (m_tuser)
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_HDR   = 2'd1;
	localparam logic [1:0] KIND_ENTRY = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_MANY = 2'd1;
	localparam logic [1:0] ST_TOO_SMALL = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_MAX_DG    = 3'd0;
	localparam logic [2:0] CFG_NDP_ALIGN = 3'd1;
	localparam logic [2:0] CFG_PAY_DIV   = 3'd2;
	localparam logic [2:0] CFG_PAY_REM   = 3'd3;
	localparam logic [2:0] CFG_WIDE      = 3'd4;

	// layout sizes in bytes
	localparam int ETH_HDR = 14;
	localparam int NTH16   = 12;
	localparam int NTH32   = 16;
	localparam int NDPH16  = 8;
	localparam int NDPH32  = 16;

	// bus widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 184;

endpackage

// ===== rtl/core/ncm_transfer_block_builder.sv =====
// Top level of the NCM transfer block builder: layout planner with entry memory.
// Start, add over the count limit, empty finish: ack goes from S_ACK into the output register.
// Add that reaches the fit check: address/fit states S_ADD_B, S_ADD_C, S_ADD_D (34-36 bit adds), then ack.
// Finish with n entries: S_FIN_A, then header, then one entry a cycle unless the output stalls,
// out of the entry memory (one registered read port), terminator last; n+2 items in all.
// Next item is taken once the last result sits in the output register.
// arst_n clears control state and config registers (max 32, align 4, div 4, rem 0, 16-bit).
module ncm_transfer_block_builder
	import ncmtb_pkg::*;
#(
	parameter int MAX_ENTRIES = NCMTB_MAX_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // buffer_size[31:0], datagram_length[47:32]
	input  logic [1:0]            s_tuser,  // req_type[1:0]
	// result channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], datagram_offset[33:2], sequence_res[49:34], table_offset[81:50],
	// block_length[113:82], table_length[129:114], entry_offset[161:130],
	// entry_length[177:162], zero pad[183:178]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,  // kind[1:0]
	output logic                  m_tlast,  // last
	// configuration writes
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);            // entry count
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int TW = CW + 5;                              // table size in bytes
	localparam int EW = OFF_W + LEN_W;                       // memory word

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_B,
		S_ADD_C,
		S_ADD_D,
		S_ACK,
		S_FIN_A,
		S_FIN_HDR,
		S_FIN_ENT,
		S_FIN_TERM
	} state_t;

	state_t state_q;

	// configuration
	logic [5:0]  max_dg_q;
	logic [15:0] ndp_align_q;
	logic [15:0] pay_div_q;
	logic [15:0] pay_rem_q;
	logic        wide_q;

	// block state
	logic [OFF_W-1:0] fill_q;
	logic [CW-1:0]    count_q;
	logic [SEQ_W-1:0] seq_q;
	logic [31:0]      buf_q;

	// per-request work registers
	logic [LEN_W-1:0] len_q;
	logic [TW-1:0]    tbl_q;
	logic [1:0]       ack_status_q;
	logic [OFF_W-1:0] ack_doff_q;
	logic [CW-1:0]    idx_q;
	logic [33:0]      a_s1;
	logic [33:0]      doff_s2;
	logic [34:0]      sum_s3;
	logic [34:0]      toff_s3;

	// output register
	logic             m_tvalid_q;
	logic [1:0]       kind_q;
	logic [1:0]       status_q;
	logic [OFF_W-1:0] doff_q;
	logic [SEQ_W-1:0] seq_out_q;
	logic [OFF_W-1:0] toff_q;
	logic [OFF_W-1:0] blen_q;
	logic [LEN_W-1:0] tlen_q;
	logic [OFF_W-1:0] eoff_q;
	logic [LEN_W-1:0] elen_q;
	logic             last_q;

	// entry memory
	logic [EW-1:0] ent_mem [MAX_ENTRIES];
	logic [EW-1:0] rdata_q;

	logic             out_free;
	logic             out_load;
	logic             accept;
	logic [15:0]      dmask;
	logic [15:0]      nmask;
	logic             lim_hit;
	logic [TW-1:0]    cnt1;
	logic [TW-1:0]    tbl_c;
	logic [35:0]      need;
	logic             fits;
	logic [OFF_W-1:0] doff_pm;
	logic [OFF_W-1:0] toff_pm;
	logic [34:0]      blen_full;
	logic [OFF_W-1:0] blen_pm;
	logic [LEN_W-1:0] tlen_c;
	logic [CW-1:0]    idx_nx;
	logic             ent_last;
	logic             wr_en;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'b0, elen_q, eoff_q, tlen_q, blen_q, toff_q, seq_out_q, doff_q,
		status_q};

	always_comb begin
		// zero alignment acts as one
		dmask = (pay_div_q == 16'd0) ? 16'd0 : pay_div_q - 16'd1;
		nmask = (ndp_align_q == 16'd0) ? 16'd0 : ndp_align_q - 16'd1;

		// limit is min(max_datagrams, MAX_ENTRIES)
		lim_hit = (32'(count_q) >= 32'(max_dg_q)) || (32'(count_q) >= 32'(MAX_ENTRIES));

		// table header + (count+1) entries
		cnt1  = TW'(count_q) + TW'(1);
		tbl_c = wide_q ? (TW'(NDPH32) + (cnt1 << 3)) : (TW'(NDPH16) + (cnt1 << 2));

		need = 36'(toff_s3) + 36'(tbl_q);
		fits = (need <= 36'(buf_q));

		doff_pm = wide_q ? doff_s2[OFF_W-1:0] : {16'b0, doff_s2[15:0]};
		toff_pm = wide_q ? toff_s3[OFF_W-1:0] : {16'b0, toff_s3[15:0]};
		tlen_c    = LEN_W'(tbl_q);
		blen_full = toff_s3 + 35'(tlen_c);
		blen_pm   = wide_q ? blen_full[OFF_W-1:0] : {16'b0, blen_full[15:0]};

		idx_nx   = idx_q + CW'(1);
		ent_last = (idx_nx == count_q);

		// a new result goes into the output register this cycle
		out_load = out_free && ((state_q == S_ACK) || (state_q == S_FIN_HDR) ||
			(state_q == S_FIN_ENT) || (state_q == S_FIN_TERM));

		wr_en   = (state_q == S_ADD_D) && fits;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == S_FIN_HDR && out_free) begin
			rd_en = 1'b1;
		end else if (state_q == S_FIN_ENT && out_free && !ent_last) begin
			rd_en   = 1'b1;
			rd_addr = idx_nx[AW-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dg_q    <= 6'd32;
			ndp_align_q <= 16'd4;
			pay_div_q   <= 16'd4;
			pay_rem_q   <= 16'd0;
			wide_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_DG:    max_dg_q    <= cfg_data[5:0];
				CFG_NDP_ALIGN: ndp_align_q <= cfg_data;
				CFG_PAY_DIV:   pay_div_q   <= cfg_data;
				CFG_PAY_REM:   pay_rem_q   <= cfg_data;
				CFG_WIDE:      wide_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[count_q[AW-1:0]] <= {doff_pm, len_q};
		end
		if (rd_en) begin
			rdata_q <= ent_mem[rd_addr];
		end
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			count_q      <= '0;
			seq_q        <= '0;
			buf_q        <= '0;
			len_q        <= '0;
			tbl_q        <= '0;
			ack_status_q <= ST_OK;
			ack_doff_q   <= '0;
			idx_q        <= '0;
			a_s1         <= '0;
			doff_s2      <= '0;
			sum_s3       <= '0;
			toff_s3      <= '0;
			m_tvalid_q   <= 1'b0;
			kind_q       <= KIND_ACK;
			status_q     <= ST_OK;
			doff_q       <= '0;
			seq_out_q    <= '0;
			toff_q       <= '0;
			blen_q       <= '0;
			tlen_q       <= '0;
			eoff_q       <= '0;
			elen_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						len_q      <= s_tdata[47:32];
						tbl_q      <= tbl_c;
						ack_doff_q <= '0;
						case (s_tuser)
							REQ_START: begin
								buf_q        <= s_tdata[31:0];
								seq_q        <= seq_q + SEQ_W'(1);
								fill_q       <= wide_q ? OFF_W'(NTH32) : OFF_W'(NTH16);
								count_q      <= '0;
								ack_status_q <= ST_OK;
								state_q      <= S_ACK;
							end
							REQ_ADD: begin
								if (lim_hit) begin
									ack_status_q <= ST_TOO_MANY;
									state_q      <= S_ACK;
								end else begin
									// align fill + Ethernet header up to the divisor
									a_s1 <= (34'(fill_q) + 34'(ETH_HDR) + 34'(dmask))
										& ~34'(dmask);
									state_q <= S_ADD_B;
								end
							end
							REQ_FINISH: begin
								if (count_q == '0) begin
									ack_status_q <= ST_EMPTY;
									state_q      <= S_ACK;
								end else begin
									state_q <= S_FIN_A;
								end
							end
							default: ;  // unknown request: no result
						endcase
					end
				end
				S_ADD_B: begin
					doff_s2 <= a_s1 + 34'(pay_rem_q) - 34'(ETH_HDR);
					state_q <= S_ADD_C;
				end
				S_ADD_C: begin
					sum_s3  <= 35'(doff_s2) + 35'(len_q);
					toff_s3 <= (35'(doff_s2) + 35'(len_q) + 35'(nmask)) & ~35'(nmask);
					state_q <= S_ADD_D;
				end
				S_ADD_D: begin
					if (fits) begin
						count_q      <= count_q + CW'(1);
						fill_q       <= sum_s3[OFF_W-1:0];
						ack_status_q <= ST_OK;
						ack_doff_q   <= doff_s2[OFF_W-1:0];
					end else begin
						ack_status_q <= ST_TOO_SMALL;
					end
					state_q <= S_ACK;
				end
				S_ACK: begin
					if (out_free) begin
						kind_q     <= KIND_ACK;
						status_q   <= ack_status_q;
						doff_q     <= ack_doff_q;
						seq_out_q  <= '0;
						toff_q     <= '0;
						blen_q     <= '0;
						tlen_q     <= '0;
						eoff_q     <= '0;
						elen_q     <= '0;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_FIN_A: begin
					toff_s3 <= (35'(fill_q) + 35'(nmask)) & ~35'(nmask);
					state_q <= S_FIN_HDR;
				end
				S_FIN_HDR: begin
					// entry 0 read goes out in the same cycle
					if (out_free) begin
						kind_q     <= KIND_HDR;
						status_q   <= ST_OK;
						doff_q     <= '0;
						seq_out_q  <= seq_q;
						toff_q     <= toff_pm;
						blen_q     <= blen_pm;
						tlen_q     <= tlen_c;
						eoff_q     <= '0;
						elen_q     <= '0;
						last_q     <= 1'b0;
						idx_q      <= '0;
						state_q    <= S_FIN_ENT;
					end
				end
				S_FIN_ENT: begin
					if (out_free) begin
						kind_q     <= KIND_ENTRY;
						status_q   <= ST_OK;
						doff_q     <= '0;
						seq_out_q  <= '0;
						toff_q     <= '0;
						blen_q     <= '0;
						tlen_q     <= '0;
						eoff_q     <= rdata_q[EW-1:LEN_W];
						elen_q     <= rdata_q[LEN_W-1:0];
						last_q     <= 1'b0;
						idx_q      <= idx_nx;
						if (ent_last) begin
							state_q <= S_FIN_TERM;
						end
					end
				end
				S_FIN_TERM: begin
					if (out_free) begin
						kind_q     <= KIND_ENTRY;
						status_q   <= ST_OK;
						doff_q     <= '0;
						seq_out_q  <= '0;
						toff_q     <= '0;
						blen_q     <= '0;
						tlen_q     <= '0;
						eoff_q     <= '0;
						elen_q     <= '0;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/ncmtb_checker.sv =====
// Port-level checker of the NCM transfer block builder and its bind.
`include "ncm_transfer_block_builder_assert.svh"

module ncmtb_checker
	import ncmtb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser,
	input logic                  m_tlast
);

	// stalled result holds
	`NCMTB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"result changed while stalled")

	// an ack or error is always the single result of its request
	`NCMTB_ASSERT_IMP(a_ack_last, m_tvalid && m_tuser == KIND_ACK, m_tlast,
		"ack without last")

	// header is always followed by entries
	`NCMTB_ASSERT_IMP(a_hdr_not_last, m_tvalid && m_tuser == KIND_HDR, !m_tlast,
		"header marked last")

	// rejected requests place nothing
	`NCMTB_ASSERT_IMP(a_err_no_offset, m_tvalid && m_tdata[1:0] != ST_OK,
		m_tdata[33:2] == 32'd0, "error carries a datagram offset")

	// terminator entry is all zero
	`NCMTB_ASSERT_IMP(a_term_zero, m_tvalid && m_tuser == KIND_ENTRY && m_tlast,
		m_tdata[177:130] == 48'd0, "terminator entry not zero")

endmodule

bind ncm_transfer_block_builder ncmtb_checker u_ncmtb_checker (.*);
